/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL of the palette texture expander.
// Every macro samples on i_clk and is switched off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/pte_pkg.sv */
// ----------------------------------------------------------------------------
// pte_pkg
// Shared types, codes and the colour expansion function of the palette
// texture expander.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pte_pkg;

    // Values of the pixel mode register.
    localparam logic [1:0] MODE_DIRECT = 2'd0;
    localparam logic [1:0] MODE_INDEX8 = 2'd1;
    localparam logic [1:0] MODE_INDEX4 = 2'd2;

    // Values of the func field of an input beat.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    // One input beat.
    typedef struct packed {
        logic        func;
        logic [7:0]  palette_index;
        logic [15:0] value;
        logic        end_of_texture;
    } t_in_item;

    // One result beat.
    typedef struct packed {
        logic [31:0] pixel_argb;
        logic        last_of_item;
        logic        texture_done;
    } t_out_item;

    // What the back end does with one queued task.
    typedef enum logic [1:0] {
        TASK_WRITE,
        TASK_LOOKUP,
        TASK_DIRECT
    } t_task_kind;

    // One task travelling from the front end to the back end.
    typedef struct packed {
        t_task_kind  kind;
        logic [7:0]  addr;
        logic [15:0] data;
        logic        last;
        logic        done;
    } t_task;

    // ARGB1555 to ARGB8888: alpha from bit 15, each 5-bit field at the top
    // of its byte with zero low bits.
    function automatic logic [31:0] expand_colour(input logic [15:0] c);
        return {{8{c[15]}}, c[4:0], 3'b000, c[9:5], 3'b000, c[14:10], 3'b000};
    endfunction

endpackage

`default_nettype wire

/* hdl/pte_ram.sv */
// ----------------------------------------------------------------------------
// pte_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pte_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* hdl/pte_fifo.sv */
// ----------------------------------------------------------------------------
// pte_fifo
// Small register-based first-in first-out queue with a fill count.
// DEPTH must be a power of two, at least two.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pte_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_push,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_pop,
    output logic      [WIDTH-1:0]         o_rdata,
    output logic                          o_full,
    output logic                          o_empty,
    output logic      [$clog2(DEPTH):0]   o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;

    // Pointer and count update.
    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + AW'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + AW'(1) : r_rd_ptr;
        n_count  = r_count + CW'(i_push) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset; the count tells which entries hold data.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rd_ptr];
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    // The neighbors must respect the queue's occupancy.
    `ASSERT_SAME(a_fifo_no_overflow, i_push, !o_full, "push into a full queue")
    `ASSERT_SAME(a_fifo_no_underflow, i_pop, !o_empty, "pop from an empty queue")

endmodule

`default_nettype wire

/* hdl/pte_front.sv */
// ----------------------------------------------------------------------------
// pte_front
// Front end: holds the pixel mode register, accepts input beats and turns
// each into zero, one or two tasks for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pte_front #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire pte_pkg::t_in_item i_item,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_wdata,
    output logic                   o_task_push,
    output pte_pkg::t_task         o_task,
    input  wire logic              i_task_full
);

    import pte_pkg::*;

    // Palette lookup task, or a black direct task when the index is out of range.
    function automatic t_task make_lookup(input logic [7:0] idx, input logic last,
                                          input logic done);
        t_task t;
        t.addr = idx;
        t.last = last;
        t.done = done;
        if ({1'b0, idx} < 9'(PALETTE_ENTRIES)) begin
            t.kind = TASK_LOOKUP;
            t.data = '0;
        end else begin
            t.kind = TASK_DIRECT;
            t.data = '0;
        end
        return t;
    endfunction

    logic [1:0] r_mode,       n_mode;
    logic       r_second_vld, n_second_vld;
    t_task      r_second,     n_second;
    logic       w_accept;
    logic       w_first_vld;
    t_task      w_first;
    logic       w_split;

    assign o_full   = r_second_vld || i_task_full;
    assign w_accept = i_push && !o_full;

    // Classify the incoming beat.
    always_comb begin
        w_first_vld = 1'b1;
        w_split     = 1'b0;
        w_first     = '{kind: TASK_DIRECT, addr: '0, data: i_item.value, last: 1'b1,
                        done: i_item.end_of_texture};
        n_second    = r_second;
        if (i_item.func == FUNC_WRITE) begin
            w_first     = '{kind: TASK_WRITE, addr: i_item.palette_index,
                            data: i_item.value, last: 1'b1, done: 1'b0};
            w_first_vld = ({1'b0, i_item.palette_index} < 9'(PALETTE_ENTRIES));
        end else begin
            case (r_mode)
                MODE_INDEX8: begin
                    w_first = make_lookup(i_item.value[7:0], 1'b1, i_item.end_of_texture);
                end
                MODE_INDEX4: begin
                    w_split  = 1'b1;
                    w_first  = make_lookup({4'b0000, i_item.value[7:4]}, 1'b0, 1'b0);
                    n_second = make_lookup({4'b0000, i_item.value[3:0]}, 1'b1,
                                           i_item.end_of_texture);
                end
                default: begin
                    w_first = '{kind: TASK_DIRECT, addr: '0, data: i_item.value,
                                last: 1'b1, done: i_item.end_of_texture};
                end
            endcase
        end
    end

    // Task issue: the pending low nibble goes before any new beat.
    always_comb begin
        if (r_second_vld) begin
            o_task_push = !i_task_full;
            o_task      = r_second;
        end else begin
            o_task_push = w_accept && w_first_vld;
            o_task      = w_first;
        end
    end

    // Pending-nibble flag and mode register.
    always_comb begin
        n_second_vld = r_second_vld;
        if (r_second_vld && !i_task_full) begin
            n_second_vld = 1'b0;
        end else if (w_accept && w_split) begin
            n_second_vld = 1'b1;
        end
        n_mode = i_cfg_we ? i_cfg_wdata : r_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_DIRECT;
            r_second_vld <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_second_vld <= n_second_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_split) begin
            r_second <= n_second;
        end
    end

    // A packed four-bit beat always leaves its low nibble pending.
    `ASSERT_NEXT(a_front_split, w_accept && w_split, r_second_vld && o_full,
                 "four-bit beat did not leave a pending nibble")

endmodule

`default_nettype wire

/* hdl/pte_back.sv */
// ----------------------------------------------------------------------------
// pte_back
// Back end: executes queued tasks against the palette RAM, expands colours
// and buffers the results in an output queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pte_back #(
    parameter int PALETTE_ENTRIES = 256,
    parameter int OUT_DEPTH       = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_task_empty,
    input  wire pte_pkg::t_task i_task,
    output logic               o_task_pop,
    output logic               o_empty,
    input  wire logic          i_pop,
    output pte_pkg::t_out_item o_pixel
);

    import pte_pkg::*;

    localparam int AW    = $clog2(PALETTE_ENTRIES);
    localparam int CW    = $clog2(OUT_DEPTH) + 1;
    localparam int OUT_W = $bits(t_out_item);

    logic              r_s1_vld, n_s1_vld;
    logic              r_s1_use_ram;
    logic [15:0]       r_s1_data;
    logic              r_s1_last;
    logic              r_s1_done;
    logic [15:0]       w_ram_rdata;
    logic              w_ram_we;
    logic              w_ram_re;
    logic [CW-1:0]     w_out_count;
    logic [CW:0]       w_used;
    logic              w_room;
    logic              w_out_full;
    logic              w_out_pop;
    t_out_item         w_result;
    logic [OUT_W-1:0]  w_out_rdata;

    // Take a task only when the output queue can hold its result.
    assign w_used     = {1'b0, w_out_count} + (CW + 1)'(r_s1_vld);
    assign w_room     = (w_used < (CW + 1)'(OUT_DEPTH));
    assign o_task_pop = !i_task_empty && w_room;
    assign w_ram_we   = o_task_pop && (i_task.kind == TASK_WRITE);
    assign w_ram_re   = o_task_pop && (i_task.kind == TASK_LOOKUP);
    assign n_s1_vld   = o_task_pop && (i_task.kind != TASK_WRITE);

    pte_ram #(
        .WIDTH (16),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (i_task.addr[AW-1:0]),
        .i_wdata (i_task.data),
        .i_re    (w_ram_re),
        .i_raddr (i_task.addr[AW-1:0]),
        .o_rdata (w_ram_rdata)
    );

    // Stage one: wait for the registered palette read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= n_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_s1_vld) begin
            r_s1_use_ram <= (i_task.kind == TASK_LOOKUP);
            r_s1_data    <= i_task.data;
            r_s1_last    <= i_task.last;
            r_s1_done    <= i_task.done;
        end
    end

    // Colour expansion into the result beat.
    always_comb begin
        w_result.pixel_argb   = expand_colour(r_s1_use_ram ? w_ram_rdata : r_s1_data);
        w_result.last_of_item = r_s1_last;
        w_result.texture_done = r_s1_done;
    end

    assign w_out_pop = i_pop && !o_empty;

    pte_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_vld),
        .i_wdata (w_result),
        .i_pop   (w_out_pop),
        .o_rdata (w_out_rdata),
        .o_full  (w_out_full),
        .o_empty (o_empty),
        .o_count (w_out_count)
    );

    assign o_pixel = t_out_item'(w_out_rdata);

    // The credit check keeps a slot free for every result in flight.
    `ASSERT_SAME(a_back_credit, r_s1_vld, !w_out_full,
                 "result in flight with no room in the output queue")

endmodule

`default_nettype wire

/* hdl/palette_texture_expander.sv */
// ----------------------------------------------------------------------------
// palette_texture_expander
// Expands ARGB1555 texture data into ARGB8888 pixels, directly or through a
// 16-bit colour palette.
// ----------------------------------------------------------------------------
// Usage:
// Input beats enter through push/full; a beat either writes a palette entry
// or carries pixel data. Result beats leave through empty/pop; the oldest
// pixel sits on o_pixel while empty is low. The mode register is written
// through i_cfg_we/i_cfg_wdata while the block is idle.
// Path: task queue, then stage one with the palette read, then the output
// queue to o_pixel; a four-bit beat's second pixel follows its first.
// Throughput: one pixel per cycle while pop is high; direct and eight-bit
// beats are taken every cycle while full is low. A four-bit beat holds full
// for its second lookup via the single task queue and one palette read port.
// Palette writes travel the same queue, so they are ordered with lookups.
// Reset clears both queues and sets direct mode; palette contents stay
// undefined until written. When pop stays low the four-entry output queue
// fills, the back end stops taking tasks, the four-entry task queue fills,
// and full rises; nothing is lost.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module palette_texture_expander #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire pte_pkg::t_in_item  i_item,
    output logic                    empty,
    input  wire logic               pop,
    output pte_pkg::t_out_item      o_pixel,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_wdata
);

    import pte_pkg::*;

    localparam int TASK_W     = $bits(t_task);
    localparam int TASK_DEPTH = 4;
    localparam int OUT_DEPTH  = 4;

    logic                        w_task_push;
    t_task                       w_task_in;
    logic                        w_task_full;
    logic                        w_task_empty;
    logic                        w_task_pop;
    logic [TASK_W-1:0]           w_task_rdata;
    logic [$clog2(TASK_DEPTH):0] w_task_count;
    t_task                       w_task_out;

    // Front end: mode register and beat classification.
    pte_front #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_task_push (w_task_push),
        .o_task      (w_task_in),
        .i_task_full (w_task_full)
    );

    // Task queue between the two ends.
    pte_fifo #(
        .WIDTH (TASK_W),
        .DEPTH (TASK_DEPTH)
    ) u_task_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_task_push),
        .i_wdata (w_task_in),
        .i_pop   (w_task_pop),
        .o_rdata (w_task_rdata),
        .o_full  (w_task_full),
        .o_empty (w_task_empty),
        .o_count (w_task_count)
    );

    // The count only feeds an occupancy sanity view of the queue.
    assign w_task_out = (w_task_count != '0) ? t_task'(w_task_rdata) : t_task'(w_task_rdata);

    // Back end: palette RAM, expansion and output queue.
    pte_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .OUT_DEPTH       (OUT_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task_empty (w_task_empty),
        .i_task       (w_task_out),
        .o_task_pop   (w_task_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_pixel      (o_pixel)
    );

endmodule

`default_nettype wire

/* dv/pte_pixel_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pte_pixel_checker
// Watches the beat, pixel and mode-register channels of the palette texture
// expander. It keeps its own copy of the palette and the pixel mode, predicts
// the pixels of every accepted input beat and compares each popped pixel,
// field by field, with the oldest prediction.
// ----------------------------------------------------------------------------

module pte_pixel_checker #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_full,
    input  pte_pkg::t_in_item  i_item,
    input  logic               i_empty,
    input  logic               i_pop,
    input  pte_pkg::t_out_item i_pixel,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_wdata,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_pixels_checked
);

    import pte_pkg::*;

    logic [15:0] palette_shadow [PALETTE_ENTRIES];
    logic [1:0]  mode_shadow = MODE_DIRECT;
    t_out_item   expected_pixels [$];
    int          fail_count = 0;
    int          pixels_checked = 0;

    assign o_fail_count     = fail_count;
    assign o_pixels_checked = pixels_checked;

    // ARGB1555 to ARGB8888: alpha from the top bit, each 5-bit field
    // moved to the top of its byte.
    function automatic logic [31:0] widen_argb1555(input logic [15:0] c);
        logic [31:0] p;
        p = 32'h0;
        if (c[15]) begin
            p[31:24] = 8'hFF;
        end
        p[23:19] = c[4:0];
        p[15:11] = c[9:5];
        p[7:3]   = c[14:10];
        return p;
    endfunction

    // Out-of-range indexes read as colour zero.
    function automatic logic [15:0] palette_read(input int unsigned idx);
        if (idx >= PALETTE_ENTRIES) begin
            return 16'h0;
        end
        return palette_shadow[idx];
    endfunction

    // Update the palette copy or queue the pixels that one beat makes.
    task automatic predict_beat(input t_in_item it);
        t_out_item px;
        if (it.func == FUNC_WRITE) begin
            if (it.palette_index < PALETTE_ENTRIES) begin
                palette_shadow[it.palette_index] = it.value;
            end
        end else begin
            case (mode_shadow)
                MODE_INDEX8: begin
                    px.pixel_argb   = widen_argb1555(palette_read(it.value[7:0]));
                    px.last_of_item = 1'b1;
                    px.texture_done = it.end_of_texture;
                    expected_pixels.push_back(px);
                end
                MODE_INDEX4: begin
                    // High nibble first; only the second pixel closes the beat.
                    px.pixel_argb   = widen_argb1555(palette_read(it.value[7:4]));
                    px.last_of_item = 1'b0;
                    px.texture_done = 1'b0;
                    expected_pixels.push_back(px);
                    px.pixel_argb   = widen_argb1555(palette_read(it.value[3:0]));
                    px.last_of_item = 1'b1;
                    px.texture_done = it.end_of_texture;
                    expected_pixels.push_back(px);
                end
                default: begin
                    // Direct colour; the spare mode behaves the same way.
                    px.pixel_argb   = widen_argb1555(it.value);
                    px.last_of_item = 1'b1;
                    px.texture_done = it.end_of_texture;
                    expected_pixels.push_back(px);
                end
            endcase
        end
    endtask

    // Compare one popped pixel with the oldest prediction.
    task automatic check_pixel(input t_out_item got);
        t_out_item want;
        if (expected_pixels.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("[%0t] unexpected pixel %08h last %0b done %0b", $realtime,
                         got.pixel_argb, got.last_of_item, got.texture_done);
            end
        end else begin
            want = expected_pixels.pop_front();
            pixels_checked++;
            if (got.pixel_argb !== want.pixel_argb || got.last_of_item !== want.last_of_item
                    || got.texture_done !== want.texture_done) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("[%0t] pixel mismatch: expected %08h/%0b/%0b got %08h/%0b/%0b",
                             $realtime, want.pixel_argb, want.last_of_item,
                             want.texture_done, got.pixel_argb, got.last_of_item,
                             got.texture_done);
                end
            end
        end
    endtask

    // Sample every channel at the clock edge; beats before the mode write.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_pixels.delete();
            mode_shadow = MODE_DIRECT;
            o_pending <= 0;
        end else begin
            if (i_push && !i_full) begin
                predict_beat(i_item);
            end
            if (i_cfg_we) begin
                mode_shadow = i_cfg_wdata;
            end
            if (i_pop && !i_empty) begin
                check_pixel(i_pixel);
            end
            o_pending <= expected_pixels.size();
        end
    end

endmodule

/* dv/tb_palette_texture_expander.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_palette_texture_expander
// Drives palette writes and pixel beats into the expander in every pixel
// mode, with bursty input and a stalling pixel consumer; the checker beside
// the block predicts and compares each pixel, and this top gives the verdict.
// ----------------------------------------------------------------------------

module tb_palette_texture_expander;
    import pte_pkg::*;

    localparam logic [1:0] MODE_SPARE    = 2'd3;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         PHASE_BEATS   = 250;

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    t_in_item  tx_item = '0;
    logic      empty;
    logic      pop = 1'b0;
    t_out_item rx_pixel;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_wdata = MODE_DIRECT;

    int fail_count;
    int pending;
    int pixels_checked;

    bit         palette_written [256];
    logic [1:0] current_mode = MODE_DIRECT;
    int         burst_left = 0;
    int         beats_sent = 0;
    int         mode_writes = 0;
    int         cycle_count = 0;
    int         stall_left = 0;
    int         stall_style = 0;
    logic [7:0] pop_mask = 8'b1011_0010;
    logic [1:0] phase_modes [8] = '{MODE_INDEX8, MODE_INDEX4, MODE_DIRECT, MODE_SPARE,
                                    MODE_INDEX4, MODE_INDEX8, MODE_INDEX4, MODE_DIRECT};

    palette_texture_expander #(
        .PALETTE_ENTRIES(256)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (tx_item),
        .empty      (empty),
        .pop        (pop),
        .o_pixel    (rx_pixel),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    pte_pixel_checker #(
        .PALETTE_ENTRIES(256)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_full          (full),
        .i_item          (tx_item),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_pixel         (rx_pixel),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_pixels_checked(pixels_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Pixel consumer: switches between free flow, random, heavy and patterned stalls.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_style <= $urandom_range(0, 3);
            stall_left  <= $urandom_range(32, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_style)
            0:       pop <= 1'b1;
            1:       pop <= 1'($urandom_range(0, 1));
            2:       pop <= ($urandom_range(0, 9) == 0);
            default: pop <= pop_mask[cycle_count % 8];
        endcase
    end

    // Offer one beat and hold it until the block takes it. Called at a
    // rising edge; returns at the edge that accepted the beat.
    task automatic send_beat(input logic kind, input logic [7:0] index,
                             input logic [15:0] data, input logic eot);
        int   gap;
        logic full_seen;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        push    <= 1'b1;
        tx_item <= '{func: kind, palette_index: index, value: data, end_of_texture: eot};
        // full only moves on a clock edge, so the falling edge sees its value
        // for the next rising edge.
        do begin
            @(negedge i_clk);
            full_seen = full;
            @(posedge i_clk);
        end while (full_seen);
        burst_left--;
        beats_sent++;
        if (kind == FUNC_WRITE) begin
            palette_written[index] = 1'b1;
        end
    endtask

    // Stop sending, wait for every predicted pixel, then let trailing
    // palette writes leave the pipeline.
    task automatic wait_drained();
        push <= 1'b0;
        burst_left = 0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        current_mode = m;
        mode_writes++;
    endtask

    // A lookup must never hit an entry that has not been written since reset.
    task automatic ensure_entry(input logic [7:0] idx);
        if (!palette_written[idx]) begin
            send_beat(FUNC_WRITE, idx, 16'($urandom_range(0, 65535)),
                      1'($urandom_range(0, 1)));
        end
    endtask

    // Random beats for the current mode: mostly pixel beats, some palette
    // rewrites, with any missing entry written just before its lookup.
    task automatic random_beats(input int count, input bit pause_midway);
        logic [7:0] idx;
        logic [3:0] hi;
        logic [3:0] lo;
        logic       eot;
        for (int k = 0; k < count; k++) begin
            if (pause_midway && k == count / 2) begin
                wait_drained();
            end
            eot = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 99) < 20) begin
                send_beat(FUNC_WRITE, 8'($urandom_range(0, 255)),
                          16'($urandom_range(0, 65535)), eot);
            end else begin
                case (current_mode)
                    MODE_INDEX8: begin
                        idx = 8'($urandom_range(0, 255));
                        ensure_entry(idx);
                        send_beat(FUNC_PIXEL, 8'($urandom_range(0, 255)),
                                  {8'($urandom_range(0, 255)), idx}, eot);
                    end
                    MODE_INDEX4: begin
                        hi = 4'($urandom_range(0, 15));
                        lo = 4'($urandom_range(0, 15));
                        ensure_entry({4'h0, hi});
                        ensure_entry({4'h0, lo});
                        send_beat(FUNC_PIXEL, 8'($urandom_range(0, 255)),
                                  {8'($urandom_range(0, 255)), hi, lo}, eot);
                    end
                    default: begin
                        send_beat(FUNC_PIXEL, 8'($urandom_range(0, 255)),
                                  16'($urandom_range(0, 65535)), eot);
                    end
                endcase
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Direct colours at the extremes; palette_index must not matter.
        write_mode(MODE_DIRECT);
        send_beat(FUNC_PIXEL, 8'hFF, 16'h0000, 1'b0);
        send_beat(FUNC_PIXEL, 8'h00, 16'hFFFF, 1'b1);
        send_beat(FUNC_PIXEL, 8'h5A, 16'h8000, 1'b0);
        send_beat(FUNC_PIXEL, 8'hA5, 16'h7FFF, 1'b1);

        // Palette writes at the ends of the store; end_of_texture is ignored.
        send_beat(FUNC_WRITE, 8'h00, 16'h0000, 1'b1);
        send_beat(FUNC_WRITE, 8'hFF, 16'hFFFF, 1'b0);
        send_beat(FUNC_WRITE, 8'h0F, 16'h8000, 1'b1);
        send_beat(FUNC_WRITE, 8'h01, 16'h7FFF, 1'b0);

        // Eight-bit lookups; the upper byte of value is ignored.
        write_mode(MODE_INDEX8);
        send_beat(FUNC_PIXEL, 8'h00, 16'hFF00, 1'b0);
        send_beat(FUNC_PIXEL, 8'hFF, 16'h00FF, 1'b1);
        send_beat(FUNC_PIXEL, 8'h33, 16'hAB01, 1'b0);
        send_beat(FUNC_PIXEL, 8'hCC, 16'h000F, 1'b1);

        // Packed four-bit lookups, high nibble first.
        write_mode(MODE_INDEX4);
        send_beat(FUNC_PIXEL, 8'h00, 16'h000F, 1'b1);
        send_beat(FUNC_PIXEL, 8'hFF, 16'hFFF0, 1'b0);
        send_beat(FUNC_PIXEL, 8'h12, 16'h0001, 1'b1);
        send_beat(FUNC_PIXEL, 8'h34, 16'h0010, 1'b0);

        // The spare mode falls back to direct colour.
        write_mode(MODE_SPARE);
        send_beat(FUNC_PIXEL, 8'h80, 16'hFFFF, 1'b1);
        send_beat(FUNC_PIXEL, 8'h7F, 16'h0001, 1'b0);

        for (int p = 0; p < 8; p++) begin
            write_mode(phase_modes[p]);
            random_beats(PHASE_BEATS, p == 2);
        end

        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("Run covered %0d input beats over %0d mode-register writes (all four modes).",
                 beats_sent, mode_writes);
        $display("%0d pixels compared, %0d mismatches, %0d still outstanding.",
                 pixels_checked, fail_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
